// ===== hw/rtl/velocity_magnitude_clamp_defines.svh =====
// ---------------------------------------------------------------------------
// Velocity magnitude clamp: assertion macros
// Shared concurrent assertion forms, clocked on clk.
// ---------------------------------------------------------------------------
`ifndef VELOCITY_MAGNITUDE_CLAMP_DEFINES_SVH
`define VELOCITY_MAGNITUDE_CLAMP_DEFINES_SVH

// Check a property outside reset.
`define VMC_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Check a property on every edge, reset included.
`define VMC_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== hw/rtl/vmc_pkg.sv =====
// ---------------------------------------------------------------------------
// Velocity magnitude clamp: package
// Shared widths, register codes and the item record passed front to back.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package vmc_pkg;

  localparam int WordW    = 32;
  localparam int LimW     = 31;
  localparam int SqW      = 64;
  localparam int RootW    = 32;
  localparam int ProdW    = 63;
  localparam int QuoW     = 31;
  localparam int SqSteps  = 32;
  localparam int DivSteps = 31;
  localparam int QDepth   = 4;
  localparam int QPtrW    = 2;

  localparam logic [LimW-1:0] LimitReset    = 31'd65536;
  localparam logic            RegSpeedLimit = 1'b0;

  typedef struct packed {
    logic [WordW-1:0] vel_x;
    logic [WordW-1:0] vel_y;
    logic [WordW-1:0] mag_x;
    logic [WordW-1:0] mag_y;
    logic             neg_x;
    logic             neg_y;
    logic             clamp;
    logic [SqW-1:0]   vel2;
  } vmc_job_t;

endpackage

`default_nettype wire

// ===== hw/rtl/velocity_magnitude_clamp.sv =====
// ---------------------------------------------------------------------------
// Velocity magnitude clamp
// Limit a 2D Q16.16 velocity to a programmed speed, keeping its direction.
// ---------------------------------------------------------------------------
//  channel | dir | payload
//  in_     | in  | tdata[31:0] vel_x_in, tdata[63:32] vel_y_in
//  out_    | out | tdata[31:0] vel_x_out, tdata[63:32] vel_y_out, tuser was_clamped
//  cfg_    | in  | APB, 0x0 speed_limit (bits 30:0)
//
//  One item per cycle sustained while out_tready holds; items pass through the
//  32-stage square root and the 31-stage dividers after it.
//  Synchronous active-low reset empties every stage and the queue and
//  loads speed_limit with 1.0.
//  An output stall freezes the back end; the front end keeps taking items
//  until the four-entry queue fills.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module velocity_magnitude_clamp (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [63:0] in_tdata,    // vel_x_in, vel_y_in
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic [63:0]      out_tdata,   // vel_x_out, vel_y_out
  output logic             out_tuser,   // was_clamped
  input  wire logic        cfg_psel,
  input  wire logic        cfg_penable,
  input  wire logic        cfg_pwrite,
  input  wire logic [2:0]  cfg_paddr,
  input  wire logic [31:0] cfg_pwdata,
  output logic [31:0]      cfg_prdata,
  output logic             cfg_pready
);
  import vmc_pkg::*;

  logic [LimW-1:0] speed_limit_r;
  logic            cfg_idx;
  vmc_job_t        fr_job, q_job;
  logic            fr_valid, fr_ready, q_valid, q_ready;

  // Register file: one word, index from the word address.
  assign cfg_pready = 1'b1;
  assign cfg_idx    = cfg_paddr[2];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      speed_limit_r <= LimitReset;
    end else if (cfg_psel && cfg_penable && cfg_pwrite && cfg_pready) begin
      if (cfg_idx == RegSpeedLimit) speed_limit_r <= cfg_pwdata[LimW-1:0];
    end
  end

  assign cfg_prdata = (cfg_idx == RegSpeedLimit) ? {1'b0, speed_limit_r} : 32'd0;

  // Classify: magnitudes, squares, compare with the squared limit.
  vmc_front u_front (
    .clk         (clk),
    .rst_n       (rst_n),
    .speed_limit (speed_limit_r),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .in_tdata    (in_tdata),
    .job         (fr_job),
    .job_valid   (fr_valid),
    .job_ready   (fr_ready)
  );

  // Decouple the two halves so each stalls on its own.
  vmc_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_job   (fr_job),
    .push_valid (fr_valid),
    .push_ready (fr_ready),
    .pop_job    (q_job),
    .pop_valid  (q_valid),
    .pop_ready  (q_ready)
  );

  // Scale: ceil sqrt, products with the limit, divide, restore signs.
  vmc_back u_back (
    .clk         (clk),
    .rst_n       (rst_n),
    .speed_limit (speed_limit_r),
    .job         (q_job),
    .job_valid   (q_valid),
    .job_ready   (q_ready),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata),
    .out_tuser   (out_tuser)
  );

endmodule

`default_nettype wire

// ===== hw/rtl/vmc_front.sv =====
// ---------------------------------------------------------------------------
// Velocity magnitude clamp: front end
// Take magnitudes, square them, sum and classify against the squared limit.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module vmc_front (
  input  wire logic                      clk,
  input  wire logic                      rst_n,
  input  wire logic [vmc_pkg::LimW-1:0]  speed_limit,
  input  wire logic                      in_tvalid,
  output logic                           in_tready,
  input  wire logic [63:0]               in_tdata,
  output vmc_pkg::vmc_job_t              job,
  output logic                           job_valid,
  input  wire logic                      job_ready
);
  import vmc_pkg::*;

  logic                  front_en;
  logic                  a_vld_r;
  logic [WordW-1:0]      a_vx_r, a_vy_r, a_mx_r, a_my_r;
  logic                  a_nx_r, a_ny_r;
  logic                  b_vld_r;
  logic [WordW-1:0]      b_vx_r, b_vy_r, b_mx_r, b_my_r;
  logic                  b_nx_r, b_ny_r;
  logic [SqW-1:0]        b_sqx_r, b_sqy_r;
  logic [2*LimW-1:0]     b_lim2_r;
  logic [WordW-1:0]      in_x, in_y;
  logic [SqW-1:0]        vel2;

  assign front_en  = !b_vld_r || job_ready;
  assign in_tready = front_en;
  assign in_x      = in_tdata[31:0];
  assign in_y      = in_tdata[63:32];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_vld_r <= 1'b0;
      b_vld_r <= 1'b0;
    end else if (front_en) begin
      a_vld_r <= in_tvalid;
      b_vld_r <= a_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (front_en) begin
      a_vx_r   <= in_x;
      a_vy_r   <= in_y;
      a_nx_r   <= in_x[WordW-1];
      a_ny_r   <= in_y[WordW-1];
      a_mx_r   <= in_x[WordW-1] ? (32'd0 - in_x) : in_x;
      a_my_r   <= in_y[WordW-1] ? (32'd0 - in_y) : in_y;
      b_vx_r   <= a_vx_r;
      b_vy_r   <= a_vy_r;
      b_mx_r   <= a_mx_r;
      b_my_r   <= a_my_r;
      b_nx_r   <= a_nx_r;
      b_ny_r   <= a_ny_r;
      b_sqx_r  <= a_mx_r * a_mx_r;
      b_sqy_r  <= a_my_r * a_my_r;
      b_lim2_r <= speed_limit * speed_limit;
    end
  end

  assign vel2      = b_sqx_r + b_sqy_r;
  assign job_valid = b_vld_r;

  always_comb begin
    job.vel_x = b_vx_r;
    job.vel_y = b_vy_r;
    job.mag_x = b_mx_r;
    job.mag_y = b_my_r;
    job.neg_x = b_nx_r;
    job.neg_y = b_ny_r;
    job.vel2  = vel2;
    job.clamp = vel2 > {2'b00, b_lim2_r};
  end

endmodule

`default_nettype wire

// ===== hw/rtl/vmc_queue.sv =====
// ---------------------------------------------------------------------------
// Velocity magnitude clamp: decoupling queue
// Short FIFO of classified items between the front and back ends.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module vmc_queue (
  input  wire logic         clk,
  input  wire logic         rst_n,
  input  vmc_pkg::vmc_job_t push_job,
  input  wire logic         push_valid,
  output logic              push_ready,
  output vmc_pkg::vmc_job_t pop_job,
  output logic              pop_valid,
  input  wire logic         pop_ready
);
  import vmc_pkg::*;

  vmc_job_t          mem_r [QDepth];
  logic [QPtrW-1:0]  wr_ptr_r, rd_ptr_r;
  logic [QPtrW:0]    count_r;
  logic              do_push, do_pop;

  assign push_ready = count_r != QDepth[QPtrW:0];
  assign pop_valid  = count_r != '0;
  assign pop_job    = mem_r[rd_ptr_r];
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop_valid && pop_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (do_push) wr_ptr_r <= wr_ptr_r + 1'b1;
      if (do_pop)  rd_ptr_r <= rd_ptr_r + 1'b1;
      if (do_push && !do_pop)      count_r <= count_r + 1'b1;
      else if (do_pop && !do_push) count_r <= count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) mem_r[wr_ptr_r] <= push_job;
  end

endmodule

`default_nettype wire

// ===== hw/rtl/vmc_back.sv =====
// ---------------------------------------------------------------------------
// Velocity magnitude clamp: back end
// Pipelined ceiling square root, limit products, two dividers, output stage.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module vmc_back (
  input  wire logic                      clk,
  input  wire logic                      rst_n,
  input  wire logic [vmc_pkg::LimW-1:0]  speed_limit,
  input  vmc_pkg::vmc_job_t              job,
  input  wire logic                      job_valid,
  output logic                           job_ready,
  output logic                           out_tvalid,
  input  wire logic                      out_tready,
  output logic [63:0]                    out_tdata,
  output logic                           out_tuser
);
  import vmc_pkg::*;

  logic back_en;

  // square root pipeline, one result bit per stage
  logic             sq_vld_r  [SqSteps+1];
  vmc_job_t         sq_job_r  [SqSteps+1];
  logic [33:0]      sq_rem_r  [SqSteps+1];
  logic [RootW-1:0] sq_root_r [SqSteps+1];
  logic [33:0]      sq_rem_nxt  [SqSteps];
  logic [RootW-1:0] sq_root_nxt [SqSteps];

  // speed and products
  logic             m_vld_r;
  vmc_job_t         m_job_r;
  logic [RootW-1:0] m_spd_r;
  logic [ProdW-1:0] m_px_r, m_py_r;

  // restoring dividers, one quotient bit per stage
  logic             dv_vld_r [DivSteps+1];
  vmc_job_t         dv_job_r [DivSteps+1];
  logic [RootW-1:0] dv_spd_r [DivSteps+1];
  logic [31:0]      dv_rx_r  [DivSteps+1];
  logic [31:0]      dv_ry_r  [DivSteps+1];
  logic [QuoW-1:0]  dv_nx_r  [DivSteps+1];
  logic [QuoW-1:0]  dv_ny_r  [DivSteps+1];
  logic [QuoW-1:0]  dv_qx_r  [DivSteps+1];
  logic [QuoW-1:0]  dv_qy_r  [DivSteps+1];
  logic [31:0]      dv_rx_nxt [DivSteps];
  logic [31:0]      dv_ry_nxt [DivSteps];
  logic [QuoW-1:0]  dv_qx_nxt [DivSteps];
  logic [QuoW-1:0]  dv_qy_nxt [DivSteps];

  logic             out_vld_r, out_clamp_r;
  logic [WordW-1:0] out_x_r, out_y_r;
  logic [WordW-1:0] res_mx, res_my;
  vmc_job_t         last_job;

  assign back_en   = !out_vld_r || out_tready;
  assign job_ready = back_en;

  always_comb begin
    logic [35:0] cur;
    logic [35:0] trial;
    for (int k = 0; k < SqSteps; k++) begin
      cur   = {sq_rem_r[k], sq_job_r[k].vel2[63-2*k -: 2]};
      trial = {2'b00, sq_root_r[k], 2'b01};
      if (cur >= trial) begin
        sq_rem_nxt[k]  = 34'(cur - trial);
        sq_root_nxt[k] = {sq_root_r[k][RootW-2:0], 1'b1};
      end else begin
        sq_rem_nxt[k]  = cur[33:0];
        sq_root_nxt[k] = {sq_root_r[k][RootW-2:0], 1'b0};
      end
    end
  end

  always_comb begin
    logic [32:0] tx;
    logic [32:0] ty;
    for (int j = 0; j < DivSteps; j++) begin
      tx = {dv_rx_r[j], dv_nx_r[j][QuoW-1]};
      ty = {dv_ry_r[j], dv_ny_r[j][QuoW-1]};
      if (tx >= {1'b0, dv_spd_r[j]}) begin
        dv_rx_nxt[j] = 32'(tx - {1'b0, dv_spd_r[j]});
        dv_qx_nxt[j] = {dv_qx_r[j][QuoW-2:0], 1'b1};
      end else begin
        dv_rx_nxt[j] = tx[31:0];
        dv_qx_nxt[j] = {dv_qx_r[j][QuoW-2:0], 1'b0};
      end
      if (ty >= {1'b0, dv_spd_r[j]}) begin
        dv_ry_nxt[j] = 32'(ty - {1'b0, dv_spd_r[j]});
        dv_qy_nxt[j] = {dv_qy_r[j][QuoW-2:0], 1'b1};
      end else begin
        dv_ry_nxt[j] = ty[31:0];
        dv_qy_nxt[j] = {dv_qy_r[j][QuoW-2:0], 1'b0};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int k = 0; k <= SqSteps; k++) sq_vld_r[k] <= 1'b0;
      for (int j = 0; j <= DivSteps; j++) dv_vld_r[j] <= 1'b0;
      m_vld_r   <= 1'b0;
      out_vld_r <= 1'b0;
    end else if (back_en) begin
      sq_vld_r[0] <= job_valid;
      for (int k = 0; k < SqSteps; k++) sq_vld_r[k+1] <= sq_vld_r[k];
      m_vld_r     <= sq_vld_r[SqSteps];
      dv_vld_r[0] <= m_vld_r;
      for (int j = 0; j < DivSteps; j++) dv_vld_r[j+1] <= dv_vld_r[j];
      out_vld_r   <= dv_vld_r[DivSteps];
    end
  end

  always_ff @(posedge clk) begin
    if (back_en) begin
      sq_job_r[0]  <= job;
      sq_rem_r[0]  <= '0;
      sq_root_r[0] <= '0;
      for (int k = 0; k < SqSteps; k++) begin
        sq_job_r[k+1]  <= sq_job_r[k];
        sq_rem_r[k+1]  <= sq_rem_nxt[k];
        sq_root_r[k+1] <= sq_root_nxt[k];
      end
      m_job_r <= sq_job_r[SqSteps];
      m_spd_r <= sq_root_r[SqSteps] + {31'd0, sq_rem_r[SqSteps] != '0};
      m_px_r  <= ProdW'(sq_job_r[SqSteps].mag_x * speed_limit);
      m_py_r  <= ProdW'(sq_job_r[SqSteps].mag_y * speed_limit);
      dv_job_r[0] <= m_job_r;
      dv_spd_r[0] <= m_spd_r;
      dv_rx_r[0]  <= m_px_r[ProdW-1:QuoW];
      dv_ry_r[0]  <= m_py_r[ProdW-1:QuoW];
      dv_nx_r[0]  <= m_px_r[QuoW-1:0];
      dv_ny_r[0]  <= m_py_r[QuoW-1:0];
      dv_qx_r[0]  <= '0;
      dv_qy_r[0]  <= '0;
      for (int j = 0; j < DivSteps; j++) begin
        dv_job_r[j+1] <= dv_job_r[j];
        dv_spd_r[j+1] <= dv_spd_r[j];
        dv_rx_r[j+1]  <= dv_rx_nxt[j];
        dv_ry_r[j+1]  <= dv_ry_nxt[j];
        dv_nx_r[j+1]  <= {dv_nx_r[j][QuoW-2:0], 1'b0};
        dv_ny_r[j+1]  <= {dv_ny_r[j][QuoW-2:0], 1'b0};
        dv_qx_r[j+1]  <= dv_qx_nxt[j];
        dv_qy_r[j+1]  <= dv_qy_nxt[j];
      end
      out_clamp_r <= last_job.clamp;
      if (last_job.clamp) begin
        out_x_r <= last_job.neg_x ? (32'd0 - res_mx) : res_mx;
        out_y_r <= last_job.neg_y ? (32'd0 - res_my) : res_my;
      end else begin
        out_x_r <= last_job.vel_x;
        out_y_r <= last_job.vel_y;
      end
    end
  end

  assign last_job = dv_job_r[DivSteps];
  assign res_mx   = {1'b0, dv_qx_r[DivSteps]};
  assign res_my   = {1'b0, dv_qy_r[DivSteps]};

  assign out_tvalid = out_vld_r;
  assign out_tdata  = {out_y_r, out_x_r};
  assign out_tuser  = out_clamp_r;

endmodule

`default_nettype wire

// ===== hw/rtl/vmc_checker.sv =====
// ---------------------------------------------------------------------------
// Velocity magnitude clamp: port checker
// Watch the top-level ports over time; bound to the top level.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
`include "velocity_magnitude_clamp_defines.svh"

module vmc_checker (
  input wire logic        clk,
  input wire logic        rst_n,
  input wire logic        out_tvalid,
  input wire logic        out_tready,
  input wire logic [63:0] out_tdata,
  input wire logic        out_tuser,
  input wire logic        cfg_pready
);

  // Hold a stalled result.
  `VMC_ASSERT(a_out_hold, out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tuser), "stalled result dropped or changed")
  // A scaled component never exceeds the limit, so it cannot be the most negative word.
  `VMC_ASSERT(a_clamp_range, out_tvalid && out_tuser |-> out_tdata[31:0] != 32'h8000_0000 && out_tdata[63:32] != 32'h8000_0000, "scaled component out of range")
  // Leave reset with an empty output.
  `VMC_ASSERT_ALWAYS(a_reset_idle, rst_n && !$past(rst_n) |-> !out_tvalid, "result shown right after reset")
  // Never wait-state the register port.
  `VMC_ASSERT(a_pready, cfg_pready, "register port not ready")

endmodule

bind velocity_magnitude_clamp vmc_checker u_vmc_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tuser  (out_tuser),
  .cfg_pready (cfg_pready)
);

`default_nettype wire

// ===== verif/vmc_clamp_checker.sv =====
// ---------------------------------------------------------------------------
// Velocity magnitude clamp: result checker
// Watches the input and result channels, predicts each clamped velocity from
// the current speed limit and compares it field by field.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module vmc_clamp_checker (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  input  wire logic        in_tready,
  input  wire logic [63:0] in_tdata,
  input  wire logic        out_tvalid,
  input  wire logic        out_tready,
  input  wire logic [63:0] out_tdata,
  input  wire logic        out_tuser,
  input  wire logic        cfg_psel,
  input  wire logic        cfg_penable,
  input  wire logic        cfg_pwrite,
  input  wire logic        cfg_pready,
  input  wire logic [2:0]  cfg_paddr,
  input  wire logic [31:0] cfg_pwdata,
  output int               fail_count,
  output int               pending_count,
  output int               clamp_count
);

  typedef struct packed {
    logic [31:0] vx;
    logic [31:0] vy;
    logic        clamped;
  } clamp_result_t;

  clamp_result_t    expected_velocities[$];
  logic [30:0]      limit_shadow;

  function automatic logic [63:0] root_ceil(logic [63:0] n);
    logic [63:0] r;
    r = 0;
    for (int b = 31; b >= 0; b--) begin
      logic [63:0] t;
      t = r | (64'd1 << b);
      if (t * t <= n) r = t;
    end
    if (r * r < n) r = r + 1;
    return r;
  endfunction

  function automatic clamp_result_t predict_clamp(logic [31:0] x, logic [31:0] y,
                                                  logic [30:0] lim);
    clamp_result_t res;
    logic [63:0] ax, ay, sq, lim2, m;
    ax   = x[31] ? 64'h1_0000_0000 - {32'd0, x} : {32'd0, x};
    ay   = y[31] ? 64'h1_0000_0000 - {32'd0, y} : {32'd0, y};
    sq   = ax * ax + ay * ay;
    lim2 = {33'd0, lim} * {33'd0, lim};
    if (sq > lim2) begin
      m = root_ceil(sq);
      ax = (ax * lim) / m;
      ay = (ay * lim) / m;
      res.vx = x[31] ? -ax[31:0] : ax[31:0];
      res.vy = y[31] ? -ay[31:0] : ay[31:0];
      res.clamped = 1'b1;
    end else begin
      res.vx = x;
      res.vy = y;
      res.clamped = 1'b0;
    end
    return res;
  endfunction

  always @(posedge clk) begin
    clamp_result_t e;
    if (!rst_n) begin
      limit_shadow  <= 31'd65536;
      fail_count    <= 0;
      clamp_count   <= 0;
      pending_count <= 0;
      expected_velocities.delete();
    end else begin
      if (cfg_psel && cfg_penable && cfg_pwrite && cfg_pready && cfg_paddr == 3'd0)
        limit_shadow <= cfg_pwdata[30:0];
      if (in_tvalid && in_tready)
        expected_velocities.insert(expected_velocities.size(),
                                   predict_clamp(in_tdata[31:0], in_tdata[63:32],
                                                 limit_shadow));
      if (out_tvalid && out_tready) begin
        if (expected_velocities.size() == 0) begin
          $error("unexpected result item %h", out_tdata);
          fail_count <= fail_count + 1;
        end else begin
          e = expected_velocities.pop_front();
          if (e.clamped) clamp_count <= clamp_count + 1;
          if (out_tdata[31:0] !== e.vx || out_tdata[63:32] !== e.vy
              || out_tuser !== e.clamped) begin
            if (out_tdata[31:0] !== e.vx)
              $error("vel_x_out expected %h actual %h", e.vx, out_tdata[31:0]);
            if (out_tdata[63:32] !== e.vy)
              $error("vel_y_out expected %h actual %h", e.vy, out_tdata[63:32]);
            if (out_tuser !== e.clamped)
              $error("was_clamped expected %b actual %b", e.clamped, out_tuser);
            fail_count <= fail_count + 1;
          end
        end
      end
      pending_count <= expected_velocities.size();
    end
  end

endmodule

`default_nettype wire

// ===== verif/tb_velocity_magnitude_clamp.sv =====
// ---------------------------------------------------------------------------
// Velocity magnitude clamp: testbench top
// Drives directed and random velocities under several speed limits with
// random idling on both channels; the checker predicts and compares.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module tb_velocity_magnitude_clamp;

  localparam int LatencyCycles = 100;
  localparam int CycleLimit    = 400000;
  localparam logic [2:0] AddrSpeedLimit = 3'd0;
  localparam logic [2:0] AddrNoRegister = 3'd4;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic [63:0] in_tdata = '0;          // vel_x_in [31:0], vel_y_in [63:32]
  logic        out_tready = 1'b0;
  logic        cfg_psel = 1'b0, cfg_penable = 1'b0, cfg_pwrite = 1'b0;
  logic [2:0]  cfg_paddr = '0;
  logic [31:0] cfg_pwdata = '0;
  wire         in_tready, out_tvalid, out_tuser, cfg_pready;
  wire  [63:0] out_tdata;               // vel_x_out [31:0], vel_y_out [63:32]
  wire  [31:0] cfg_prdata;              // speed_limit [30:0]
  int          fail_count, pending_count, clamp_count;
  int          sender_idle_pct, receiver_idle_pct;
  int          cycle_count = 0;
  int          items_sent = 0;
  int          limits_used = 0;
  bit          hold_receiver = 1'b0;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  velocity_magnitude_clamp dut (.*);

  vmc_clamp_checker checker_i (.*);

  // Abort on a hang.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CycleLimit) begin
      $display("timeout after %0d cycles", cycle_count);
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  // Receiver: idle at the current rate, or hold off entirely while asked.
  always @(negedge clk) begin
    if (!rst_n) out_tready <= 1'b0;
    else out_tready <= !hold_receiver && ($urandom_range(99) >= receiver_idle_pct);
  end

  // Offer one item and hold it until taken; gaps before it at the sender rate.
  task automatic send_velocity(input logic [31:0] x, input logic [31:0] y);
    while ($urandom_range(99) < sender_idle_pct) begin
      in_tvalid <= 1'b0;
      @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {y, x};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    items_sent++;
    @(negedge clk);
  endtask

  // Let every expected item drain, then give the pipeline time to settle.
  task automatic drain_results();
    in_tvalid <= 1'b0;
    while (pending_count != 0) @(negedge clk);
    repeat (LatencyCycles) @(negedge clk);
  endtask

  // Write the speed limit through a setup and an access phase.
  task automatic write_limit(input logic [31:0] value, input logic [2:0] addr);
    cfg_psel <= 1'b1; cfg_pwrite <= 1'b1; cfg_paddr <= addr; cfg_pwdata <= value;
    @(negedge clk);
    cfg_penable <= 1'b1;
    @(posedge clk);
    while (!cfg_pready) @(posedge clk);
    @(negedge clk);
    cfg_psel <= 1'b0; cfg_penable <= 1'b0; cfg_pwrite <= 1'b0;
    limits_used++;
    @(negedge clk);
  endtask

  // Mix of small, near-limit and full-range components.
  function automatic logic [31:0] pick_component(input logic [30:0] lim);
    case ($urandom_range(3))
      0: return $urandom;
      1: return $urandom_range(0, 2 * lim + 1) - lim;
      2: return {{16{1'b0}}, 16'($urandom)} ^ {32{1'($urandom_range(1))}};
      default: return ($urandom_range(1)) ? 32'h8000_0000 + $urandom_range(255)
                                          : 32'h7FFF_FFFF - $urandom_range(255);
    endcase
  endfunction

  task automatic random_phase(input int count, input logic [30:0] lim);
    for (int i = 0; i < count; i++) send_velocity(pick_component(lim), pick_component(lim));
  endtask

  logic [30:0] limits [6];

  initial begin
    limits = '{31'd65536, 31'd0, 31'h7FFF_FFFF, 31'd1, 31'd3 << 16, 31'd0};
    limits[5] = 31'($urandom);
    sender_idle_pct   = 24;
    receiver_idle_pct = 56;
    repeat (12) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Directed: reset limit of 1.0, exact-limit and extreme components.
    send_velocity(32'h0001_0000, 32'h0);           // speed equals limit
    send_velocity(32'h0, 32'hFFFF_0000);           // negative, equal to limit
    send_velocity(32'h0001_0001, 32'h0);           // just above
    send_velocity(32'h8000_0000, 32'h8000_0000);   // most negative both
    send_velocity(32'h7FFF_FFFF, 32'h8000_0000);
    send_velocity(32'h0, 32'h0);
    send_velocity(32'hFFFF_FFFF, 32'h0000_0001);
    send_velocity(32'h0000_C000, 32'h0000_C000);   // 1.06 speed, clamped
    send_velocity(32'h5555_5555, 32'hAAAA_AAAA);
    drain_results();
    // Bits above 30 and a foreign address are ignored.
    write_limit(32'hFFFF_FFFF, AddrNoRegister);
    write_limit(32'h8000_0000, AddrSpeedLimit);    // limit becomes zero
    send_velocity(32'h0, 32'h0);
    send_velocity(32'h0, 32'h0000_0001);
    send_velocity(32'h8000_0000, 32'h7FFF_FFFF);
    drain_results();

    // Random phases across limits and idling profiles.
    for (int p = 0; p < 6; p++) begin
      if (p == 2) begin
        sender_idle_pct = 56; receiver_idle_pct = 24;
      end else if (p == 4) begin
        sender_idle_pct = 0; receiver_idle_pct = 0;
      end
      write_limit({1'b0, limits[p]}, AddrSpeedLimit);
      if (p == 3) begin
        // Stall the output long enough that the input backs up.
        fork
          begin
            hold_receiver = 1'b1;
            repeat (300) @(negedge clk);
            hold_receiver = 1'b0;
          end
          random_phase(230, limits[p]);
        join
      end else begin
        random_phase(230, limits[p]);
      end
      drain_results();
    end

    $display("%0d velocities sent over %0d limit writes, %0d clamped",
             items_sent, limits_used, clamp_count);
    if (fail_count == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

`default_nettype wire
